// ===== src/graph_attack_robustness_assert.svh =====
// assertion macros for the graph attack robustness block
`ifndef GRAPH_ATTACK_ROBUSTNESS_ASSERT_SVH
`define GRAPH_ATTACK_ROBUSTNESS_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define GAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication with the consequent checked in the following cycle
`define GAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/gar_pkg.sv =====
// shared types and constants for the graph attack robustness block
package gar_pkg;
    localparam int ROW_W = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int SUM_W = 12;
    localparam int RQ_W  = 16;

    typedef logic [ROW_W-1:0] t_row;

    // popcount of a masked row
    function automatic logic [CNT_W-1:0] f_popcount(input t_row v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int k = 0; k < ROW_W; k++) begin
            c = c + CNT_W'(v[k]);
        end
        return c;
    endfunction
endpackage

// ===== src/gar_lane.sv =====
// one lane: degree and activity of a slice of nodes, reports its best candidate
module gar_lane #(
    parameter int LANE_NODES = 8,
    parameter int BASE       = 0
) (
    input  logic                    i_clk,
    input  logic [LANE_NODES*7-1:0] i_deg,
    input  logic [LANE_NODES-1:0]   i_act,
    output logic                    o_found,
    output logic [5:0]              o_idx,
    output logic [6:0]              o_deg
);
    logic                    r_found;
    logic [5:0]              r_idx;
    logic [6:0]              r_deg;
    logic                    n_found;
    logic [5:0]              n_idx;
    logic [6:0]              n_deg;

    // lowest index among the maximal active degrees of the slice
    always_comb begin
        n_found = 1'b0;
        n_idx   = 6'(BASE);
        n_deg   = '0;
        for (int k = 0; k < LANE_NODES; k++) begin
            if (i_act[k] && (!n_found || i_deg[k*7 +: 7] > n_deg)) begin
                n_found = 1'b1;
                n_idx   = 6'(BASE + k);
                n_deg   = i_deg[k*7 +: 7];
            end
        end
    end

    // registered lane result
    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_idx   <= n_idx;
        r_deg   <= n_deg;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_deg   = r_deg;
endmodule

// ===== src/gar_merge.sv =====
// merging stage: picks the best lane candidate, lowest lane wins ties
module gar_merge #(
    parameter int LANES = 8
) (
    input  logic [LANES-1:0]   i_found,
    input  logic [LANES*6-1:0] i_idx,
    input  logic [LANES*7-1:0] i_deg,
    output logic               o_found,
    output logic [5:0]         o_idx
);
    logic [6:0] v_deg;

    // strict greater keeps the lower lane on ties
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        v_deg   = '0;
        for (int l = 0; l < LANES; l++) begin
            if (i_found[l] && (!o_found || i_deg[l*7 +: 7] > v_deg)) begin
                o_found = 1'b1;
                o_idx   = i_idx[l*6 +: 6];
                v_deg   = i_deg[l*7 +: 7];
            end
        end
    end
endmodule

// ===== src/graph_attack_robustness.sv =====
// top level: row loading, targeted attack sequencer and cluster walk
//
//  channel | signals                                  | direction
//  in      | i_valid/o_ready, row_index/bits/last_row | in
//  out     | o_valid/i_ready, cluster_sum, robust q16 | out
//  cfg     | i_cfg_we, i_cfg_data (node_count)        | in
//
// an item with last_row also starts the attack: a degree rebuild pass, then per
// round a lane pick, merge and delete of the target if any, a seek per cluster
// start and to close the round, a walk and expand per node visited, and a walk
// to close each cluster walk; then 16 shift-subtract divide steps, a result load
// reset is synchronous active low, no clearing pass; rows must all be written
// input is refused while the attack runs; the result load waits on a held result
module graph_attack_robustness #(
    parameter int MAX_NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_row_index,
    input  logic [63:0] i_row_bits,
    input  logic        i_last_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_cluster_sum,
    output logic [15:0] o_robustness_q16,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data
);
    import gar_pkg::*;

    localparam int ROWS   = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int LANES  = 8;
    localparam int LN     = 8;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PICK  = 4'd1;
    localparam logic [3:0] S_MERGE = 4'd2;
    localparam logic [3:0] S_DEL   = 4'd3;
    localparam logic [3:0] S_SEEK  = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_EXPD  = 4'd8;
    localparam logic [3:0] S_COPY  = 4'd9;

    logic [3:0]  r_state;
    logic [6:0]  r_ncfg;
    t_row        r_adj  [64];
    t_row        r_rdata;
    logic [6:0]  r_deg  [64];
    t_row        r_act;
    t_row        r_vis;
    t_row        r_stk;   // pending frontier bits
    logic [6:0]  r_size;
    logic [6:0]  r_best;
    logic [11:0] r_sum;
    logic [6:0]  r_round;
    logic [5:0]  r_tgt;
    logic [6:0]  r_ci;
    logic [5:0]  r_cd;
    logic        r_cpend;
    logic [27:0] r_rem;
    logic [15:0] r_quo;
    logic [4:0]  r_dstep;
    logic        r_ovalid;

    logic [6:0]  v_n;
    t_row        v_mask;
    logic [LANES-1:0]   w_found;
    logic [LANES*6-1:0] w_idx;
    logic [LANES*7-1:0] w_ldeg;
    logic        w_mfound;
    logic [5:0]  w_midx;
    t_row        v_free;
    logic [5:0]  v_low;
    logic [5:0]  v_node;
    t_row        v_next;
    logic [13:0] v_nsq;
    logic [28:0] v_trial;
    logic [5:0]  v_raddr;
    logic        w_we;
    logic        w_oload;

    // saturated node count and column mask
    always_comb begin
        v_n = r_ncfg;
        if (v_n == 7'd0) v_n = 7'd1;
        if (v_n > 7'(ROWS)) v_n = 7'(ROWS);
        v_mask = (v_n >= 7'd64) ? '1 : ((t_row'(1) << v_n[5:0]) - t_row'(1));
        v_nsq  = 14'(v_n) * 14'(v_n);
    end

    // lanes over slices of the node degrees
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [LN*7-1:0] w_d;
        for (genvar k = 0; k < LN; k++) begin : g_d
            assign w_d[k*7 +: 7] = r_deg[g*LN + k];
        end
        gar_lane #(.LANE_NODES(LN), .BASE(g*LN)) u_lane (
            .i_clk  (i_clk),
            .i_deg  (w_d),
            .i_act  (r_act[g*LN +: LN] & v_mask[g*LN +: LN]),
            .o_found(w_found[g]),
            .o_idx  (w_idx[g*6 +: 6]),
            .o_deg  (w_ldeg[g*7 +: 7])
        );
    end

    gar_merge #(.LANES(LANES)) u_merge (
        .i_found(w_found),
        .i_idx  (w_idx),
        .i_deg  (w_ldeg),
        .o_found(w_mfound),
        .o_idx  (w_midx)
    );

    // lowest set bit and frontier helpers for the walk, and the divide trial
    always_comb begin
        v_free = r_act & ~r_vis;
        v_low  = '0;
        for (int k = 63; k >= 0; k--) begin
            if (v_free[k]) v_low = 6'(k);
        end
        v_node = '0;
        for (int k = 63; k >= 0; k--) begin
            if (r_stk[k]) v_node = 6'(k);
        end
        v_next  = r_rdata & r_act & ~r_vis;
        v_trial = {r_rem, 1'b0} - {15'd0, v_nsq};
    end

    // row memory read address: target pick, walk node or rebuild index
    always_comb begin
        if (r_state == S_MERGE) begin
            v_raddr = w_midx;
        end else if (r_state == S_WALK) begin
            v_raddr = v_node;
        end else begin
            v_raddr = r_ci[5:0];
        end
    end

    assign o_ready = (r_state == S_LOAD);
    assign w_we    = i_valid && o_ready && (7'(i_row_index) < 7'(ROWS));
    assign w_oload = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // adjacency row memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_adj[i_row_index] <= i_row_bits;
        r_rdata <= r_adj[v_raddr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            o_cluster_sum    <= r_sum;
            o_robustness_q16 <= r_quo;
            r_ovalid         <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ncfg   <= 7'd64;
            r_act    <= '1;
        end else begin
            if (i_cfg_we) r_ncfg <= i_cfg_data;
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid && o_ready) begin
                        if (7'(i_row_index) < 7'(ROWS)) begin
                            r_deg[i_row_index] <= f_popcount(i_row_bits & v_mask);
                        end
                        if (i_last_row) begin
                            r_ci    <= '0;
                            r_cpend <= 1'b0;
                            r_state <= S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    // one row read per cycle, its degree written in the cycle after
                    if (r_cpend) r_deg[r_cd] <= f_popcount(r_rdata & v_mask);
                    r_cd <= r_ci[5:0];
                    if (r_ci < v_n) begin
                        r_cpend <= 1'b1;
                        r_ci    <= r_ci + 7'd1;
                    end else begin
                        r_cpend <= 1'b0;
                        r_act   <= v_mask;
                        r_sum   <= '0;
                        r_round <= 7'd1;
                        r_state <= (v_n > 7'd1) ? S_PICK : S_DIV;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_dstep <= '0;
                    end
                end
                S_PICK: r_state <= S_MERGE;
                S_MERGE: begin
                    r_tgt   <= w_midx;
                    r_state <= w_mfound ? S_DEL : S_SEEK;
                    r_vis   <= '0;
                    r_best  <= 7'd1;
                    r_stk   <= '0;
                end
                S_DEL: begin
                    // edges to deleted nodes stay in the rows, masked by activity
                    for (int k = 0; k < 64; k++) begin
                        if (6'(k) == r_tgt) begin
                            r_deg[k] <= '0;
                        end else if (r_rdata[k] && v_mask[k] && r_deg[k] != 7'd0) begin
                            r_deg[k] <= r_deg[k] - 7'd1;
                        end
                    end
                    r_act[r_tgt] <= 1'b0;
                    r_state      <= S_SEEK;
                end
                S_SEEK: begin
                    if (v_free == '0) begin
                        r_sum <= r_sum + 12'(r_best);
                        if (r_round + 7'd1 >= v_n) begin
                            r_state <= S_DIV;
                            r_rem   <= {16'd0, r_sum + 12'(r_best)};
                        end else begin
                            r_round <= r_round + 7'd1;
                            r_state <= S_PICK;
                        end
                    end else begin
                        r_vis[v_low] <= 1'b1;
                        r_stk        <= t_row'(1) << v_low;
                        r_size       <= '0;
                        r_state      <= S_WALK;
                    end
                end
                S_WALK: begin
                    // order of visits does not change cluster size
                    if (r_stk == '0) begin
                        if (r_size > r_best) r_best <= r_size;
                        r_state <= S_SEEK;
                    end else begin
                        r_stk   <= r_stk & ~(t_row'(1) << v_node);
                        r_size  <= r_size + 7'd1;
                        r_state <= S_EXPD;
                    end
                end
                S_EXPD: begin
                    // row of the popped node is back from memory
                    r_stk   <= r_stk | v_next;
                    r_vis   <= r_vis | v_next;
                    r_state <= S_WALK;
                end
                S_DIV: begin
                    // restoring division of sum<<16 by n squared
                    if (!v_trial[28]) begin
                        r_rem <= v_trial[27:0];
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[26:0], 1'b0};
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_dstep <= r_dstep + 5'd1;
                    if (r_dstep == 5'd15) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_oload) begin
                        r_act   <= '1;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid = r_ovalid;

    `include "graph_attack_robustness_assert.svh"

    `GAR_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_LOAD, !o_ready)
    `GAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_cluster_sum))
    `GAR_ASSERT_IMPL(a_size_range, i_clk, i_rst_n, r_state == S_WALK, r_size <= 7'd64)
endmodule
